[hw/rtl/tpsp_pkg.sv]
// Shared types and constants for the trie page statistics parser.
// No dependencies; used by the walker, the emitter and the top level.
package tpsp_pkg;

  localparam int HeaderBytes = 9;
  localparam int BaseLevel   = 14;
  localparam int HistBins    = 9;
  localparam int NumStats    = 25;
  localparam int NumCnt      = 22;

  localparam logic [4:0] LevelId = 5'd25;
  localparam logic [3:0] LevelNone = 4'd9;

  localparam logic [1:0] ModeNode   = 2'd0;
  localparam logic [1:0] ModeChild  = 2'd1;
  localparam logic [1:0] ModeLeaves = 2'd2;
  localparam logic [1:0] ModeSkip   = 2'd3;

  localparam int CntNodes  = 0;
  localparam int CntBoth   = 1;
  localparam int CntPcount = 2;
  localparam int CntPlen   = 3;
  localparam int CntLeaf   = 4;
  localparam int CntChild  = 13;

  localparam logic signed [47:0] T48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] T48Min = 48'sh8000_0000_0000;

  typedef logic [24:0] pv_t;

  // Per-page values handed from the walker to the emitter.
  typedef struct packed {
    logic              kind;
    logic [3:0]        lvl;
    pv_t [NumStats-1:0] pv;
  } snap_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

[hw/rtl/tpsp_walker.sv]
// Byte walker: header capture, trie walk and per-page counters.
// Depends on tpsp_pkg; hands a finished page to the emitter as a snapshot.
module tpsp_walker (
  input  logic           clk,
  input  logic           rst,
  input  logic [16:0]    page_bytes,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  logic [7:0]     page_byte,
  input  logic           snap_full,
  output logic           snap_load,
  output tpsp_pkg::snap_t snap
);

  logic [16:0] byte_position, byte_position_next;
  logic [15:0] hdr0, hdr1, hdr2, hdr0_next, hdr1_next, hdr2_next;
  logic [7:0]  page_flags, page_flags_next;
  logic [1:0]  parse_mode, parse_mode_next;
  logic [9:0]  skip_remaining, skip_remaining_next;
  logic [7:0]  child_bitmap, child_bitmap_next;
  logic [23:0] cnt [tpsp_pkg::NumCnt];
  logic [23:0] cnt_next [tpsp_pkg::NumCnt];

  logic [17:0] limit;
  logic        at_last, fire, in_trie;
  logic [17:0] trie_end;
  logic [3:0]  pc_b, pc_c;
  logic [5:0]  lvl_diff;

  always_comb begin
    if (page_bytes < 17'd16) begin
      limit = 18'd16;
    end else if (page_bytes > 17'd65536) begin
      limit = 18'd65536;
    end else begin
      limit = {1'b0, page_bytes};
    end
  end

  assign at_last    = ({1'b0, byte_position} + 18'd1) >= limit;
  assign byte_ready = !(at_last && snap_full);
  assign fire       = byte_valid && byte_ready;
  assign trie_end   = 18'(tpsp_pkg::HeaderBytes) + {2'b0, hdr2};
  assign in_trie    = (byte_position >= 17'(tpsp_pkg::HeaderBytes)) &&
                      ({1'b0, byte_position} < trie_end);
  assign pc_b       = tpsp_pkg::popcnt8(page_byte);
  assign pc_c       = tpsp_pkg::popcnt8(child_bitmap);

  always_comb begin
    page_flags_next     = page_flags;
    hdr0_next           = hdr0;
    hdr1_next           = hdr1;
    hdr2_next           = hdr2;
    parse_mode_next     = parse_mode;
    skip_remaining_next = skip_remaining;
    child_bitmap_next   = child_bitmap;
    cnt_next            = cnt;
    case (byte_position)
      17'd0: page_flags_next = page_byte;
      17'd1: hdr0_next[15:8] = page_byte;
      17'd2: hdr0_next[7:0]  = page_byte;
      17'd3: hdr1_next[15:8] = page_byte;
      17'd4: hdr1_next[7:0]  = page_byte;
      17'd6: hdr2_next[15:8] = page_byte;
      17'd7: hdr2_next[7:0]  = page_byte;
      default: ;
    endcase
    case (parse_mode)
      tpsp_pkg::ModeNode: begin
        if (in_trie) begin
          cnt_next[tpsp_pkg::CntNodes] = cnt[tpsp_pkg::CntNodes] + 24'd1;
          if (page_byte[0]) begin
            cnt_next[tpsp_pkg::CntPcount] = cnt[tpsp_pkg::CntPcount] + 24'd1;
            cnt_next[tpsp_pkg::CntPlen]   = cnt[tpsp_pkg::CntPlen] + {17'd0, page_byte[7:1]};
            skip_remaining_next = {3'd0, page_byte[7:1]};
            parse_mode_next = (page_byte[7:1] != 7'd0) ? tpsp_pkg::ModeSkip
                                                       : tpsp_pkg::ModeNode;
          end else if (page_byte[1]) begin
            parse_mode_next = tpsp_pkg::ModeChild;
          end else begin
            child_bitmap_next = '0;
            parse_mode_next   = tpsp_pkg::ModeLeaves;
          end
        end
      end
      tpsp_pkg::ModeChild: begin
        child_bitmap_next = page_byte;
        cnt_next[tpsp_pkg::CntChild + int'(pc_b)] =
          cnt[tpsp_pkg::CntChild + int'(pc_b)] + 24'd1;
        parse_mode_next = tpsp_pkg::ModeLeaves;
      end
      tpsp_pkg::ModeLeaves: begin
        if (child_bitmap != 8'd0 && page_byte != 8'd0) begin
          cnt_next[tpsp_pkg::CntBoth] = cnt[tpsp_pkg::CntBoth] + 24'd1;
        end
        cnt_next[tpsp_pkg::CntLeaf + int'(pc_b)] =
          cnt[tpsp_pkg::CntLeaf + int'(pc_b)] + 24'd1;
        skip_remaining_next = {4'd0, ({1'b0, pc_b} + {1'b0, pc_c}), 1'b0};
        parse_mode_next = ((pc_b | pc_c) != 4'd0) ? tpsp_pkg::ModeSkip
                                                  : tpsp_pkg::ModeNode;
      end
      default: begin
        if (skip_remaining != 10'd0) begin
          skip_remaining_next = skip_remaining - 10'd1;
        end
        if (skip_remaining_next == 10'd0) begin
          parse_mode_next = tpsp_pkg::ModeNode;
        end
      end
    endcase
    byte_position_next = byte_position + 17'd1;
  end

  // Snapshot of the finished page, built from the values after the last byte.
  always_comb begin
    snap.kind = page_flags_next[7];
    lvl_diff  = {1'b0, page_flags_next[4:0]} - 6'(tpsp_pkg::BaseLevel);
    if ({1'b0, page_flags_next[4:0]} >= 6'(tpsp_pkg::BaseLevel) &&
        lvl_diff < 6'(tpsp_pkg::HistBins)) begin
      snap.lvl = lvl_diff[3:0];
    end else begin
      snap.lvl = tpsp_pkg::LevelNone;
    end
    snap.pv[0] = {9'd0, hdr2_next};
    snap.pv[1] = {9'd0, hdr0_next};
    snap.pv[2] = 25'(limit) - {9'd0, hdr1_next};
    snap.pv[3] = {1'b0, cnt_next[tpsp_pkg::CntNodes]};
    snap.pv[4] = {1'b0, cnt_next[tpsp_pkg::CntBoth]};
    snap.pv[5] = {1'b0, cnt_next[tpsp_pkg::CntPcount]};
    snap.pv[6] = {1'b0, cnt_next[tpsp_pkg::CntPlen]};
    for (int k = 0; k < tpsp_pkg::HistBins; k++) begin
      snap.pv[7 + k]  = {1'b0, cnt_next[tpsp_pkg::CntLeaf + k]};
      snap.pv[16 + k] = {1'b0, cnt_next[tpsp_pkg::CntChild + k]};
    end
  end

  assign snap_load = fire && at_last;

  always_ff @(posedge clk) begin
    if (rst || snap_load) begin
      byte_position  <= '0;
      hdr0           <= '0;
      hdr1           <= '0;
      hdr2           <= '0;
      page_flags     <= '0;
      parse_mode     <= tpsp_pkg::ModeNode;
      skip_remaining <= '0;
      child_bitmap   <= '0;
      for (int i = 0; i < tpsp_pkg::NumCnt; i++) begin
        cnt[i] <= '0;
      end
    end else if (fire) begin
      byte_position  <= byte_position_next;
      hdr0           <= hdr0_next;
      hdr1           <= hdr1_next;
      hdr2           <= hdr2_next;
      page_flags     <= page_flags_next;
      parse_mode     <= parse_mode_next;
      skip_remaining <= skip_remaining_next;
      child_bitmap   <= child_bitmap_next;
      cnt            <= cnt_next;
    end
  end

  // A page may only close when the emitter can take its snapshot.
  ap_no_overrun: assert property (@(posedge clk) disable iff (rst)
    snap_load |-> !snap_full) else $error("page closed over a full snapshot");
  ap_skip_mode: assert property (@(posedge clk) disable iff (rst)
    (parse_mode == tpsp_pkg::ModeSkip) |-> (skip_remaining != 10'd0))
    else $error("skip mode with nothing to skip");
  ap_stall_only_at_end: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> at_last) else $error("input stalled mid-page");

endmodule

[hw/rtl/tpsp_emitter.sv]
// Result emitter: walks a page snapshot, updates the per-kind and per-level
// totals and drives the result register. Depends on tpsp_pkg.
module tpsp_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_load,
  input  tpsp_pkg::snap_t snap_in,
  output logic            snap_full,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [4:0]      out_id,
  output logic [17:0]     out_page,
  output logic [47:0]     out_total,
  output logic            out_kind,
  output logic            out_last
);

  tpsp_pkg::snap_t snap;
  logic [4:0]  a_idx;
  logic        a_fire, b_fire;
  logic        b_valid, b_kind;
  logic [4:0]  b_idx;
  logic [5:0]  b_addr, a_addr;
  logic [24:0] b_pv, a_pv;
  logic [3:0]  b_lvl;
  logic [47:0] mem [50];
  logic [49:0] mem_vld;
  logic [47:0] rd_data;
  logic        rd_vld;
  logic [47:0] lvl_tot [tpsp_pkg::HistBins];
  logic [47:0] cur, total, lvl_inc;
  logic signed [48:0] sum;

  assign a_fire = snap_full && (!b_valid || b_fire);
  assign b_fire = b_valid && (!out_valid || out_ready);
  assign a_addr = (snap.kind ? 6'd25 : 6'd0) + {1'b0, a_idx};
  assign a_pv   = (a_idx == tpsp_pkg::LevelId) ? {21'd0, snap.lvl} : snap.pv[a_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_full <= 1'b0;
      a_idx     <= '0;
      b_valid   <= 1'b0;
    end else begin
      if (snap_load) begin
        snap_full <= 1'b1;
      end else if (a_fire && a_idx == tpsp_pkg::LevelId) begin
        snap_full <= 1'b0;
      end
      if (a_fire) begin
        a_idx   <= (a_idx == tpsp_pkg::LevelId) ? 5'd0 : a_idx + 5'd1;
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap <= snap_in;
    end
    if (a_fire) begin
      b_idx   <= a_idx;
      b_addr  <= a_addr;
      b_pv    <= a_pv;
      b_lvl   <= snap.lvl;
      b_kind  <= snap.kind;
      rd_data <= mem[a_addr];
      rd_vld  <= mem_vld[a_addr];
    end
    if (b_fire && b_idx != tpsp_pkg::LevelId) begin
      mem[b_addr] <= total;
    end
  end

  always_comb begin
    cur     = rd_vld ? rd_data : 48'd0;
    sum     = {cur[47], cur} + {{24{b_pv[24]}}, b_pv};
    lvl_inc = '0;
    if (b_lvl < tpsp_pkg::LevelNone) begin
      lvl_inc = (lvl_tot[b_lvl] == tpsp_pkg::T48Max) ? lvl_tot[b_lvl]
                                                     : lvl_tot[b_lvl] + 48'd1;
    end
    if (b_idx == tpsp_pkg::LevelId) begin
      total = lvl_inc;
    end else if (sum > 49'(tpsp_pkg::T48Max)) begin
      total = tpsp_pkg::T48Max;
    end else if (sum < 49'(tpsp_pkg::T48Min)) begin
      total = tpsp_pkg::T48Min;
    end else begin
      total = sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < tpsp_pkg::HistBins; i++) begin
        lvl_tot[i] <= '0;
      end
    end else begin
      if (b_fire) begin
        out_valid <= 1'b1;
        if (b_idx == tpsp_pkg::LevelId) begin
          if (b_lvl < tpsp_pkg::LevelNone) begin
            lvl_tot[b_lvl] <= lvl_inc;
          end
        end else begin
          mem_vld[b_addr] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_id    <= b_idx;
      out_page  <= b_pv[17:0];
      out_total <= total;
      out_kind  <= b_kind;
      out_last  <= (b_idx == tpsp_pkg::LevelId);
    end
  end

  ap_idx_busy: assert property (@(posedge clk) disable iff (rst)
    (a_idx != 5'd0) |-> snap_full) else $error("walk index moved without a snapshot");
  ap_no_reload: assert property (@(posedge clk) disable iff (rst)
    snap_load |-> !snap_full || (a_fire && a_idx == tpsp_pkg::LevelId))
    else $error("snapshot overwritten while in use");
  ap_last_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_id == tpsp_pkg::LevelId))
    else $error("last flag on a result other than the level");

endmodule

[hw/rtl/trie_page_stats_parser.sv]
// Trie page statistics parser: the first result of a page passes the snapshot register,
// the read stage and the result register after the transfer of its last byte; the 26
// results then follow one per cycle when taken. Throughput is one byte per cycle; a
// page end stalls input only while the previous page's 26 results have not all been
// walked (with every result taken at once, pages of 27 bytes or more never stall).
// Reset is synchronous and active high: page state, totals and page_bytes (4096)
// return to their initial values at once, with no clearing pass.
module trie_page_stats_parser (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: page_bytes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  // Input stream: one page byte per transfer.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] page_byte
  // Result stream: 26 transfers per page, tlast on the level result.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [4:0] stat_id, [22:5] page_value, [70:23] total_value
  output logic        m_tuser,   // [0] is_leaf_page
  output logic        m_tlast
);

  logic [16:0]     page_bytes;
  logic            snap_full, snap_load;
  tpsp_pkg::snap_t snap;
  logic [4:0]      stat_id;
  logic [17:0]     page_value;
  logic [47:0]     total_value;

  // The register is always writable; writes must happen only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= 17'd4096;
    end else if (cfg_valid) begin
      page_bytes <= cfg_data;
    end
  end

  // The walker updates header words and counters for every accepted byte and
  // hands a completed page over as one snapshot.
  tpsp_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .page_bytes (page_bytes),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .page_byte  (s_tdata),
    .snap_full  (snap_full),
    .snap_load  (snap_load),
    .snap       (snap)
  );

  // The emitter turns the snapshot into 26 results while the next page streams in.
  tpsp_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .snap_load (snap_load),
    .snap_in   (snap),
    .snap_full (snap_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_id    (stat_id),
    .out_page  (page_value),
    .out_total (total_value),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, total_value, page_value, stat_id};

endmodule
